FILE: sv/lspp_pkg.sv
`default_nettype none

package lspp_pkg;

    // Decoder phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DESC,
        PH_WAIT,
        PH_CAPTURE
    } phase_t;

    // Input action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_BEGIN   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNC_BAD = 2'd1;
    localparam logic [1:0] ST_SUM_BAD  = 2'd2;
    localparam logic [1:0] ST_BROKEN   = 2'd3;

    // Packet first-byte start flags (bits 1..0)
    localparam logic [1:0] FLAG_START    = 2'b01;
    localparam logic [1:0] FLAG_NO_START = 2'b10;

    // Descriptor checks
    localparam logic [7:0] DESC_SYNC = 8'hFF;
    localparam logic [7:0] DESC_SUM  = 8'hC4;
    localparam logic [2:0] DESC_SYNC_END = 3'd2;
    localparam logic [2:0] DESC_LEN      = 3'd7;

    // Packet layout
    localparam logic [2:0] PKT_LAST = 3'd4;

    // Capture limits
    localparam int          POINT_W    = 10;
    localparam logic [9:0]  MAX_POINTS = 10'd512;
    localparam logic [15:0] IDLE_LIMIT_RESET = 16'd1000;

    // Configuration register index (byte address 4*i)
    localparam logic REG_IDLE_LIMIT = 1'b0;

    // One result item
    typedef struct packed {
        logic                has_point;
        logic [14:0]         angle_q6;
        logic [15:0]         distance_q2;
        logic [7:0]          quality_byte;
        logic                scan_done;
        logic [1:0]          status;
        logic [POINT_W-1:0]  point_count;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/lidar_scan_packet_parser_top.sv
// Scan measurement packet decoder.
//
// Input channel (s_*): one transaction per received byte. s_tuser carries the
// action (0 byte, 1 receive timeout taken as a zero byte, 2 begin a new scan),
// s_tdata the byte. A begin restarts the 7-byte descriptor check; the block
// then skips 5-byte packets until a start-of-scan packet and decodes points.
// Result channel (m_*): at most one transaction per input transaction, either
// a point (m_tuser has_point set) or the end of the scan (m_tlast set, with
// the status in m_tuser). A point that reaches the point limit is also last.
// Configuration: APB register 0 (address 0) is idle_limit, reset 1000; write
// it only while no transaction is in flight.
// Path: an input transaction is held in the input register, then decoded into
// the output register that drives m_tvalid and the result. Throughput is one
// transaction per cycle while m_tready stays high.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to idle, where bytes are dropped until a begin arrives.
// When m_tready is low the held result waits, the input register fills and
// s_tready drops once both stages are full; nothing is lost.
`default_nettype none

module lidar_scan_packet_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] action
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [14:0] angle_q6, [30:15] distance_q2,
                                        // [38:31] quality_byte, [48:39] point_count
    output logic [2:0]       m_tuser,   // [0] has_point, [2:1] status
    output logic             m_tlast,   // scan_done
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        in_vld_reg;
    logic [1:0]  in_act_reg;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    lspp_pkg::result_t out_reg;
    logic [15:0] idle_limit_reg;

    logic        out_free;
    logic        fire;
    logic        res_vld;
    lspp_pkg::result_t res;
    logic        cfg_wr;
    logic        reg_hit;

    assign out_free = !out_vld_reg || m_tready;
    assign fire     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_act_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    lspp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (fire),
        .step_act   (in_act_reg),
        .step_byte  (in_byte_reg),
        .idle_limit (idle_limit_reg),
        .res_vld    (res_vld),
        .res        (res)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= fire && res_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_vld) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg.point_count, out_reg.quality_byte,
                       out_reg.distance_q2, out_reg.angle_q6};
    assign m_tuser  = {out_reg.status, out_reg.has_point};
    assign m_tlast  = out_reg.scan_done;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == lspp_pkg::REG_IDLE_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? {16'd0, idle_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_limit_reg <= lspp_pkg::IDLE_LIMIT_RESET;
        end else if (cfg_wr) begin
            idle_limit_reg <= pwdata[15:0];
        end
    end

endmodule

`default_nettype wire

FILE: sv/lspp_core.sv
`default_nettype none

module lspp_core (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [1:0]       step_act,
    input  wire logic [7:0]       step_byte,
    input  wire logic [15:0]      idle_limit,
    output logic                  res_vld,
    output lspp_pkg::result_t     res
);

    lspp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic [7:0]  sync_or_reg, sync_or_next;
    logic [7:0]  check_xor_reg, check_xor_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic [9:0]  points_reg, points_next;
    logic [7:0]  pkt_reg [0:3];

    logic        is_data, is_begin;
    logic [7:0]  b;
    logic [2:0]  bi_inc;
    logic [16:0] idle_inc;
    logic [15:0] pkt_distance;
    logic [14:0] ang;
    logic        chk_ok;
    logic [9:0]  pts_inc;
    logic        pts_done;

    logic        end_scan;
    logic [1:0]  end_status;
    logic        take_pkt;
    logic        to_wait, to_capture;
    logic        idle_bump;
    logic        store_en;
    logic        emit;

    // Decode the step and precompute packet fields
    always_comb begin
        is_data  = step_en && (step_act == lspp_pkg::ACT_BYTE ||
                               step_act == lspp_pkg::ACT_TIMEOUT);
        is_begin = step_en && (step_act == lspp_pkg::ACT_BEGIN);
        b        = (step_act == lspp_pkg::ACT_BYTE) ? step_byte : 8'd0;
        bi_inc   = byte_index_reg + 3'd1;
        idle_inc = {1'b0, idle_count_reg} + 17'd1;
        pkt_distance = {b, pkt_reg[3]};
        ang      = {pkt_reg[2], pkt_reg[1][7:1]};
        chk_ok   = pkt_reg[1][0] && (pkt_distance != 16'd0);
        pts_inc  = points_reg + 10'd1;
        pts_done = (pts_inc >= lspp_pkg::MAX_POINTS);
    end

    // Work out what this byte does in the current phase
    always_comb begin
        end_scan        = 1'b0;
        end_status      = lspp_pkg::ST_OK;
        take_pkt        = 1'b0;
        to_wait         = 1'b0;
        to_capture      = 1'b0;
        idle_bump       = 1'b0;
        store_en        = 1'b0;
        byte_index_next = byte_index_reg;
        sync_or_next    = sync_or_reg;
        check_xor_next  = check_xor_reg;
        unique case (phase_reg)
            lspp_pkg::PH_DESC: begin
                if (byte_index_reg < lspp_pkg::DESC_SYNC_END) begin
                    sync_or_next = sync_or_reg | b;
                end else begin
                    check_xor_next = check_xor_reg ^ b;
                end
                byte_index_next = bi_inc;
                if (bi_inc == lspp_pkg::DESC_SYNC_END && sync_or_next != lspp_pkg::DESC_SYNC) begin
                    end_scan   = 1'b1;
                    end_status = lspp_pkg::ST_SYNC_BAD;
                end else if (bi_inc == lspp_pkg::DESC_LEN) begin
                    byte_index_next = 3'd0;
                    if (check_xor_next != lspp_pkg::DESC_SUM) begin
                        end_scan   = 1'b1;
                        end_status = lspp_pkg::ST_SUM_BAD;
                    end else begin
                        to_wait = 1'b1;
                    end
                end
            end
            lspp_pkg::PH_WAIT: begin
                if (byte_index_reg == 3'd0) begin
                    if (b == 8'd0) begin
                        if (idle_inc > {1'b0, idle_limit}) begin
                            end_scan = 1'b1;
                        end else begin
                            idle_bump = 1'b1;
                        end
                    end else begin
                        store_en        = 1'b1;
                        byte_index_next = 3'd1;
                    end
                end else if (byte_index_reg == lspp_pkg::PKT_LAST) begin
                    byte_index_next = 3'd0;
                    if (pkt_reg[0][1:0] == lspp_pkg::FLAG_START) begin
                        if (idle_count_reg >= idle_limit) begin
                            end_scan = 1'b1;
                        end else begin
                            to_capture = 1'b1;
                            take_pkt   = 1'b1;
                        end
                    end
                end else begin
                    store_en        = 1'b1;
                    byte_index_next = bi_inc;
                end
            end
            lspp_pkg::PH_CAPTURE: begin
                if (byte_index_reg == 3'd0) begin
                    if (b[1:0] != lspp_pkg::FLAG_NO_START) begin
                        end_scan = 1'b1;
                        if (b == 8'd0) begin
                            if (idle_inc < {1'b0, idle_limit}) begin
                                end_scan  = 1'b0;
                                idle_bump = 1'b1;
                            end
                        end else if (b[1:0] != lspp_pkg::FLAG_START) begin
                            end_status = lspp_pkg::ST_BROKEN;
                        end
                    end else begin
                        store_en        = 1'b1;
                        byte_index_next = 3'd1;
                    end
                end else if (byte_index_reg == lspp_pkg::PKT_LAST) begin
                    byte_index_next = 3'd0;
                    take_pkt        = 1'b1;
                end else begin
                    store_en        = 1'b1;
                    byte_index_next = bi_inc;
                end
            end
            lspp_pkg::PH_IDLE: begin
            end
        endcase
        emit = take_pkt && chk_ok;
    end

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        priority if (is_begin) begin
            phase_next = lspp_pkg::PH_DESC;
        end else if (is_data) begin
            priority if (end_scan) begin
                phase_next = lspp_pkg::PH_IDLE;
            end else if (emit && pts_done) begin
                phase_next = lspp_pkg::PH_IDLE;
            end else if (to_capture) begin
                phase_next = lspp_pkg::PH_CAPTURE;
            end else if (to_wait) begin
                phase_next = lspp_pkg::PH_WAIT;
            end else begin
                phase_next = phase_reg;
            end
        end else begin
            phase_next = phase_reg;
        end
    end

    // Build the result transaction
    always_comb begin
        res_vld          = is_data && (end_scan || emit);
        res.has_point    = emit && !end_scan;
        res.angle_q6     = '0;
        res.distance_q2  = '0;
        res.quality_byte = '0;
        res.scan_done    = 1'b1;
        res.status       = end_status;
        res.point_count  = points_reg;
        if (!end_scan) begin
            res.angle_q6     = ang;
            res.distance_q2  = pkt_distance;
            res.quality_byte = pkt_reg[0];
            res.scan_done    = pts_done;
            res.status       = lspp_pkg::ST_OK;
            res.point_count  = pts_inc;
        end
    end

    // Counter next values
    always_comb begin
        idle_count_next = idle_count_reg;
        points_next     = points_reg;
        if (idle_bump) begin
            idle_count_next = idle_inc[15:0];
        end
        if (emit) begin
            points_next = pts_inc;
        end
    end

    // Advance decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= lspp_pkg::PH_IDLE;
            byte_index_reg <= 3'd0;
            sync_or_reg    <= 8'd0;
            check_xor_reg  <= 8'd0;
            idle_count_reg <= 16'd0;
            points_reg     <= 10'd0;
        end else if (is_begin) begin
            phase_reg      <= phase_next;
            byte_index_reg <= 3'd0;
            sync_or_reg    <= 8'd0;
            check_xor_reg  <= 8'd0;
            idle_count_reg <= 16'd0;
            points_reg     <= 10'd0;
        end else if (is_data) begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            sync_or_reg    <= sync_or_next;
            check_xor_reg  <= check_xor_next;
            idle_count_reg <= idle_count_next;
            points_reg     <= points_next;
        end
    end

    // Hold packet bytes 0..3; byte 4 is used straight from the input
    always_ff @(posedge aclk) begin
        if (is_data && store_en) begin
            pkt_reg[byte_index_reg[1:0]] <= b;
        end
    end

    // Checks
    a_points_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        points_reg <= lspp_pkg::MAX_POINTS)
        else $error("point count passed the maximum");

    a_desc_index: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg < lspp_pkg::DESC_LEN)
        else $error("byte index out of range");

    a_pkt_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == lspp_pkg::PH_WAIT || phase_reg == lspp_pkg::PH_CAPTURE)
        |-> byte_index_reg <= lspp_pkg::PKT_LAST)
        else $error("packet byte index out of range");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_vld && res.scan_done) |=> phase_reg == lspp_pkg::PH_IDLE)
        else $error("scan end did not return to idle");

    a_point_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_vld && res.has_point) |-> (res.status == lspp_pkg::ST_OK &&
                                         res.distance_q2 != 16'd0))
        else $error("point result with bad status or zero distance");

endmodule

`default_nettype wire

FILE: bench/lidar_scan_packet_parser_top_tb.sv
`timescale 1ns / 1ps

module lidar_scan_packet_parser_top_tb;

    // Codes the package leaves out
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam logic [1:0] FLAG_NONE    = 2'b00;
    localparam logic [1:0] FLAG_BOTH    = 2'b11;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } rx_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = lspp_pkg::ACT_BYTE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    lidar_scan_packet_parser_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    // Decoder state mirrored by the scoreboard
    lspp_pkg::phase_t dec_phase = lspp_pkg::PH_IDLE;
    logic [2:0]  dec_index      = '0;
    logic [7:0]  dec_pkt [5];
    logic [7:0]  dec_sync_or    = '0;
    logic [7:0]  dec_sum_xor    = '0;
    logic [15:0] dec_idle_cnt   = '0;
    logic [9:0]  dec_points     = '0;
    logic [15:0] cfg_idle_limit = lspp_pkg::IDLE_LIMIT_RESET;

    rx_item_t pending_items [$];
    lspp_pkg::result_t expected_results [$];
    rx_item_t next_item;
    lspp_pkg::result_t pred_res;
    lspp_pkg::result_t want_res;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_queued  = 0;
    int items_taken   = 0;
    int fail_count    = 0;
    int points_seen   = 0;
    int scans_ended   = 0;
    int end_status_count [4] = '{0, 0, 0, 0};

    // ---------------------------------------------------------------
    // Scan decoder prediction
    // ---------------------------------------------------------------

    function automatic bit close_scan(input logic [1:0] st, output lspp_pkg::result_t res);
        dec_phase = lspp_pkg::PH_IDLE;
        res = '0;
        res.scan_done = 1'b1;
        res.status = st;
        res.point_count = dec_points;
        return 1'b1;
    endfunction

    // Turn the five stored packet bytes into a point, if it carries one
    function automatic bit emit_point(output lspp_pkg::result_t res);
        logic [15:0] distance;
        res = '0;
        distance = {dec_pkt[4], dec_pkt[3]};
        if (!dec_pkt[1][0] || distance == '0) return 1'b0;
        dec_points++;
        if (dec_points >= lspp_pkg::MAX_POINTS) begin
            dec_phase = lspp_pkg::PH_IDLE;
            res.scan_done = 1'b1;
        end
        res.has_point    = 1'b1;
        res.angle_q6     = {dec_pkt[2], dec_pkt[1][7:1]};
        res.distance_q2  = distance;
        res.quality_byte = dec_pkt[0];
        res.status       = lspp_pkg::ST_OK;
        res.point_count  = dec_points;
        return 1'b1;
    endfunction

    function automatic bit decode_step(input logic [1:0] act, input logic [7:0] rx,
                                       output lspp_pkg::result_t res);
        logic [7:0]  b;
        logic [16:0] next_idle;
        res = '0;
        b = (act == lspp_pkg::ACT_BYTE) ? rx : 8'd0;
        if (act == lspp_pkg::ACT_BEGIN) begin
            dec_phase    = lspp_pkg::PH_DESC;
            dec_index    = '0;
            dec_sync_or  = '0;
            dec_sum_xor  = '0;
            dec_idle_cnt = '0;
            dec_points   = '0;
            return 1'b0;
        end
        if (act == ACT_RESERVED) return 1'b0;
        next_idle = {1'b0, dec_idle_cnt} + 17'd1;
        case (dec_phase)
            lspp_pkg::PH_DESC: begin
                if (dec_index < lspp_pkg::DESC_SYNC_END) dec_sync_or |= b;
                else dec_sum_xor ^= b;
                dec_index++;
                if (dec_index == lspp_pkg::DESC_SYNC_END &&
                    dec_sync_or != lspp_pkg::DESC_SYNC)
                    return close_scan(lspp_pkg::ST_SYNC_BAD, res);
                if (dec_index == lspp_pkg::DESC_LEN) begin
                    dec_index = '0;
                    if (dec_sum_xor != lspp_pkg::DESC_SUM)
                        return close_scan(lspp_pkg::ST_SUM_BAD, res);
                    dec_phase = lspp_pkg::PH_WAIT;
                end
                return 1'b0;
            end
            lspp_pkg::PH_WAIT: begin
                if (dec_index == '0) begin
                    if (b == '0) begin
                        if (next_idle > {1'b0, cfg_idle_limit})
                            return close_scan(lspp_pkg::ST_OK, res);
                        dec_idle_cnt = next_idle[15:0];
                        return 1'b0;
                    end
                    dec_pkt[0] = b;
                    dec_index = 3'd1;
                    return 1'b0;
                end
                dec_pkt[dec_index] = b;
                if (dec_index != lspp_pkg::PKT_LAST) begin
                    dec_index++;
                    return 1'b0;
                end
                dec_index = '0;
                if (dec_pkt[0][1:0] != lspp_pkg::FLAG_START) return 1'b0;
                if (dec_idle_cnt >= cfg_idle_limit)
                    return close_scan(lspp_pkg::ST_OK, res);
                dec_phase = lspp_pkg::PH_CAPTURE;
                return emit_point(res);
            end
            lspp_pkg::PH_CAPTURE: begin
                if (dec_index == '0) begin
                    if (b[1:0] != lspp_pkg::FLAG_NO_START) begin
                        if (b == '0) begin
                            if (next_idle >= {1'b0, cfg_idle_limit})
                                return close_scan(lspp_pkg::ST_OK, res);
                            dec_idle_cnt = next_idle[15:0];
                            return 1'b0;
                        end
                        if (b[1:0] == lspp_pkg::FLAG_START)
                            return close_scan(lspp_pkg::ST_OK, res);
                        return close_scan(lspp_pkg::ST_BROKEN, res);
                    end
                    dec_pkt[0] = b;
                    dec_index = 3'd1;
                    return 1'b0;
                end
                dec_pkt[dec_index] = b;
                if (dec_index != lspp_pkg::PKT_LAST) begin
                    dec_index++;
                    return 1'b0;
                end
                dec_index = '0;
                return emit_point(res);
            end
            default: return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input driver: predict on each accepted transaction, then reload
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                items_taken++;
                if (decode_step(s_tuser, s_tdata, pred_res))
                    expected_results.push_back(pred_res);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_item.action;
                    s_tdata  <= next_item.rx_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with none pending: tdata %h tuser %h tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    check_field("has_point", want_res.has_point, m_tuser[0]);
                    check_field("angle_q6", want_res.angle_q6, m_tdata[14:0]);
                    check_field("distance_q2", want_res.distance_q2, m_tdata[30:15]);
                    check_field("quality_byte", want_res.quality_byte, m_tdata[38:31]);
                    check_field("scan_done", want_res.scan_done, m_tlast);
                    check_field("status", want_res.status, m_tuser[2:1]);
                    check_field("point_count", want_res.point_count, m_tdata[48:39]);
                end
                if (m_tuser[0]) points_seen++;
                if (m_tlast) begin
                    scans_ended++;
                    end_status_count[m_tuser[2:1]]++;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic push_item(input logic [1:0] act, input logic [7:0] b);
        pending_items.push_back('{action: act, rx_byte: b});
        items_queued++;
    endtask

    // A zero byte arrives either as a real zero or as a receive timeout
    task automatic push_zero();
        if ($urandom_range(0, 2) == 0) push_item(lspp_pkg::ACT_TIMEOUT, 8'($urandom));
        else push_item(lspp_pkg::ACT_BYTE, 8'd0);
    endtask

    task automatic push_data(input logic [7:0] b);
        if (b == '0) push_zero();
        else push_item(lspp_pkg::ACT_BYTE, b);
    endtask

    task automatic push_noise(input int count);
        repeat (count) push_item(2'($urandom), 8'($urandom));
    endtask

    // One 5-byte packet; force_point guarantees check bit and nonzero distance
    task automatic push_packet(input logic [1:0] flags, input bit force_point);
        logic [7:0]  head;
        logic [7:0]  check_byte;
        logic [15:0] distance;
        head = {6'($urandom), flags};
        if (head == '0) head[2] = 1'b1;
        check_byte = 8'($urandom);
        check_byte[0] = force_point || ($urandom_range(0, 99) < 85);
        distance = 16'($urandom);
        if (!force_point && $urandom_range(0, 9) == 0) distance = '0;
        else if (distance == '0) distance = 16'd1;
        push_item(lspp_pkg::ACT_BYTE, head);
        push_data(check_byte);
        push_data(8'($urandom));
        push_data(distance[7:0]);
        push_data(distance[15:8]);
    endtask

    // Mostly valid descriptors, with some sync and checksum faults
    task automatic push_descriptor();
        logic [7:0] d [7];
        logic [7:0] sum;
        logic [7:0] mask;
        int         mode;
        mode = $urandom_range(0, 99);
        mask = 8'(1 << $urandom_range(0, 7));
        d[0] = 8'($urandom);
        d[1] = ~d[0] | 8'($urandom);
        if (mode < 7) begin
            d[0] &= ~mask;
            d[1] &= ~mask;
        end
        sum = lspp_pkg::DESC_SUM;
        for (int i = 2; i < 6; i++) begin
            d[i] = 8'($urandom);
            sum ^= d[i];
        end
        d[6] = sum;
        if (mode >= 7 && mode < 15) d[6] ^= mask;
        for (int i = 0; i < 7; i++) push_data(d[i]);
    endtask

    task automatic push_idle_run();
        int count;
        count = $urandom_range(0, 2);
        if (cfg_idle_limit <= 40 && $urandom_range(0, 9) == 0)
            count = cfg_idle_limit + $urandom_range(0, 1);
        repeat (count) push_zero();
    endtask

    task automatic push_scan();
        int n_skip;
        int n_pts;
        if ($urandom_range(0, 4) == 0) push_noise($urandom_range(1, 3));
        push_item(lspp_pkg::ACT_BEGIN, 8'($urandom));
        push_descriptor();
        // packets skipped while waiting for the scan start
        n_skip = $urandom_range(0, 3);
        repeat (n_skip) begin
            push_idle_run();
            case ($urandom_range(0, 2))
                0:       push_packet(FLAG_NONE, 1'b0);
                1:       push_packet(FLAG_BOTH, 1'b0);
                default: push_packet(lspp_pkg::FLAG_NO_START, 1'b0);
            endcase
        end
        push_idle_run();
        push_packet(lspp_pkg::FLAG_START, 1'b0);
        n_pts = $urandom_range(0, 14);
        repeat (n_pts) begin
            if ($urandom_range(0, 3) == 0) push_idle_run();
            push_packet(lspp_pkg::FLAG_NO_START, 1'b0);
        end
        // close the scan one of several ways
        case ($urandom_range(0, 4))
            0: push_packet(lspp_pkg::FLAG_START, 1'b0);
            1: push_packet($urandom_range(0, 1) ? FLAG_BOTH : FLAG_NONE, 1'b0);
            2: if (cfg_idle_limit <= 40) repeat (cfg_idle_limit) push_zero();
            3: ;
            default: push_noise($urandom_range(1, 4));
        endcase
    endtask

    task automatic push_directed();
        // dropped before any begin
        push_item(lspp_pkg::ACT_BYTE, 8'h55);
        push_item(ACT_RESERVED, 8'hAA);
        // descriptor with extreme byte values
        push_item(lspp_pkg::ACT_BEGIN, 8'hFF);
        push_item(lspp_pkg::ACT_BYTE, 8'hFF);
        push_item(lspp_pkg::ACT_TIMEOUT, 8'hFF);
        push_item(lspp_pkg::ACT_BYTE, lspp_pkg::DESC_SUM);
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        push_item(lspp_pkg::ACT_TIMEOUT, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, 8'hFF);
        push_item(lspp_pkg::ACT_BYTE, 8'hFF);
        // idle read, then start packet with maximum angle and distance
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, {6'd0, lspp_pkg::FLAG_START});
        repeat (4) push_item(lspp_pkg::ACT_BYTE, 8'hFF);
        // zero distance, then a broken first byte
        push_item(lspp_pkg::ACT_BYTE, {6'h3F, lspp_pkg::FLAG_NO_START});
        push_item(lspp_pkg::ACT_BYTE, 8'h01);
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        push_item(lspp_pkg::ACT_TIMEOUT, 8'h80);
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, {6'h01, FLAG_BOTH});
        push_item(lspp_pkg::ACT_BYTE, 8'h10);
        // descriptor sync fault
        push_item(lspp_pkg::ACT_BEGIN, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, 8'h00);
        // descriptor checksum fault
        push_item(lspp_pkg::ACT_BEGIN, 8'h00);
        push_item(lspp_pkg::ACT_BYTE, 8'h80);
        push_item(lspp_pkg::ACT_BYTE, 8'h7F);
        repeat (5) push_item(lspp_pkg::ACT_BYTE, 8'h00);
    endtask

    // Hold until everything queued has gone through and the pipe is empty
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_idle_limit(input logic [15:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {lspp_pkg::REG_IDLE_LIMIT, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_idle_limit = value;
    endtask

    task automatic run_phase(input bit set_limit, input logic [15:0] limit,
                             input int idle_pct, input int stall, input int n_items);
        int first_item;
        wait_drained();
        if (set_limit) write_idle_limit(limit);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        first_item    = items_queued;
        while (items_queued - first_item < n_items) push_scan();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        push_directed();
        run_phase(1'b0, lspp_pkg::IDLE_LIMIT_RESET, 0, 0, 180);
        run_phase(1'b1, 16'd1, 52, 0, 210);
        run_phase(1'b1, 16'hFFFF, 0, 52, 210);
        run_phase(1'b1, 16'($urandom_range(2, 12)), 8, 8, 210);
        run_phase(1'b1, 16'($urandom_range(13, 300)), 0, 0, 210);
        run_phase(1'b1, 16'd2, 52, 52, 210);
        wait_drained();
        $display("Sent %0d byte/timeout/begin transactions under six idle-limit settings;",
                 items_taken);
        $display("got %0d points and %0d scan ends (ok %0d, sync %0d, checksum %0d, broken %0d).",
                 points_seen, scans_ended, end_status_count[lspp_pkg::ST_OK],
                 end_status_count[lspp_pkg::ST_SYNC_BAD],
                 end_status_count[lspp_pkg::ST_SUM_BAD],
                 end_status_count[lspp_pkg::ST_BROKEN]);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
